FILE: hw/rtl/srmr_pkg.sv
// Shared constants and types for the stereo-to-mono linear resampler.
package srmr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 16;
    localparam int STEP_W      = 17;  // Q16 phase step, max 97390
    localparam int PHASE_W     = 18;  // phase plus one step before wrap
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 30;

    localparam logic [RATE_W-1:0]  OUT_RATE_HZ = 16'd44100;
    localparam logic [RATE_W-1:0]  MIN_RATE_HZ = 16'd8000;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd65536;  // 44100 -> 1.0 in Q16
    localparam logic [PHASE_W-1:0] ONE_Q16     = 18'd65536;
    // ceil(2^44 / 11025): 65536/44100 scaled by 2^30, exact for any 16-bit rate
    localparam logic [RECIP_W-1:0] STEP_RECIP  = 31'd1595663134;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_PREP = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_ADD  = 5'b10000
    } state_t;

endpackage

FILE: hw/rtl/stereo_to_mono_linear_resampler_unit.sv
// Top level of the stereo-to-mono linear-interpolation resampler to 44.1 kHz.
// Usage:
//   s_ channel: one input word per handshake - left/right samples and a
//   stereo flag. Stereo words are mixed as floor((L+R)/2), mono words use left.
//   m_ channel: interpolated mono words at 44.1 kHz; m_last marks the final
//   output word produced by an input word. An input word may give 0 to 6
//   output words (none is possible when the input rate exceeds 44.1 kHz).
//   cfg_ channel: writes the input rate in Hz; values below 8000 act as 8000.
//   A write holds the block while the step updates.
// Sequence:
//   An input word holds the block through its acceptance, a phase check, then
//   a multiply and an add state per output word, all on the single 17x17
//   multiplier and adder. The first output word is registered in the add
//   state, which waits while the output register still holds a word.
// Reset:
//   Rate returns to 44100 (step 1.0), previous sample and phase to zero.
// Stalls:
//   The output register holds one word. When it is full and m_ready is low
//   the add stage waits; after the last output of a word is registered a new
//   input word can already be accepted while that output still waits.
module stereo_to_mono_linear_resampler_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [srmr_pkg::RATE_W-1:0]            cfg_data,
    // input words
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [srmr_pkg::SAMPLE_W-1:0]   s_left_sample,
    input  logic signed [srmr_pkg::SAMPLE_W-1:0]   s_right_sample,
    input  logic                                   s_stereo,
    // output words
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [srmr_pkg::SAMPLE_W-1:0]   m_out_sample,
    output logic                                   m_last
);
    import srmr_pkg::*;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]          step_reg,   step_next;
    logic [PHASE_W-1:0]         phase_reg,  phase_next;
    logic signed [SAMPLE_W-1:0] prev_reg,   prev_next;
    logic signed [SAMPLE_W-1:0] x_reg,      x_next;
    logic [SAMPLE_W-1:0]        prod_reg,   prod_next;   // floor(diff*phase/65536)
    logic                       flag_reg,   flag_next;   // current output is the last
    logic                       mval_reg,   mval_next;
    logic signed [SAMPLE_W-1:0] mout_reg,   mout_next;
    logic                       mlast_reg,  mlast_next;

    logic                       cfg_fire, s_fire, out_free;
    logic                       div_busy;
    logic [STEP_W-1:0]          div_q;
    logic signed [SAMPLE_W:0]   mix_sum;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [2*SAMPLE_W+1:0] product;
    logic [PHASE_W-1:0]         phase_adv;

    srmr_step_div u_step_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_fire),
        .rate     (cfg_data),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // config has priority over an input word in the idle state
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !mval_reg || m_ready;

    always_comb begin
        // arithmetic shift of the 17-bit sum is floor((L+R)/2)
        mix_sum   = {s_left_sample[SAMPLE_W-1], s_left_sample}
                  + {s_right_sample[SAMPLE_W-1], s_right_sample};
        diff      = {x_reg[SAMPLE_W-1], x_reg} - {prev_reg[SAMPLE_W-1], prev_reg};
        // phase is below 1.0 here, only its fraction enters the product
        product   = diff * $signed({1'b0, phase_reg[SAMPLE_W-1:0]});
        phase_adv = phase_reg + {{(PHASE_W-STEP_W){1'b0}}, step_reg};

        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        prev_next  = prev_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        flag_next  = flag_reg;
        mout_next  = mout_reg;
        mlast_next = mlast_reg;
        mval_next  = (mval_reg && m_ready) ? 1'b0 : mval_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_fire) begin
                    state_next = ST_STEP;
                end else if (s_fire) begin
                    x_next     = s_stereo ? mix_sum[SAMPLE_W:1] : s_left_sample;
                    state_next = ST_PREP;
                end
            end
            ST_STEP: begin
                if (!div_busy) begin
                    step_next  = div_q;
                    state_next = ST_IDLE;
                end
            end
            ST_PREP: begin
                if (phase_reg < ONE_Q16) begin
                    state_next = ST_MUL;
                end else begin
                    // no output for this word, only the phase wraps
                    phase_next = phase_reg - ONE_Q16;
                    prev_next  = x_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                prod_next  = product[2*SAMPLE_W-1:SAMPLE_W];
                phase_next = phase_adv;
                flag_next  = (phase_adv >= ONE_Q16);
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    mout_next  = prev_reg + $signed(prod_reg);
                    mlast_next = flag_reg;
                    if (flag_reg) begin
                        phase_next = phase_reg - ONE_Q16;
                        prev_next  = x_reg;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RESET;
            phase_reg <= '0;
            prev_reg  <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            mval_reg  <= mval_next;
        end
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        flag_reg  <= flag_next;
        mout_reg  <= mout_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid      = mval_reg;
    assign m_out_sample = mout_reg;
    assign m_last       = mlast_reg;

    // an accepted input word always goes to the phase check next
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_PREP)
        else $error("input word accepted but phase check skipped");

    // a rate write always starts the step update
    a_cfg_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> div_busy && state_reg == ST_STEP)
        else $error("rate write did not start the step update");

    // wrapped phase stays below the largest step
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> phase_reg < 18'd97391)
        else $error("phase out of range between words");

    // clamp keeps the step at or above the 8 kHz value
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg >= 17'd11888)
        else $error("phase step below minimum");

endmodule

FILE: hw/rtl/srmr_step_div.sv
// Phase step unit: step = floor(max(rate, 8000) * 65536 / 44100) by reciprocal multiplication.
module srmr_step_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [srmr_pkg::RATE_W-1:0]    rate,
    output logic                           busy,
    output logic [srmr_pkg::STEP_W-1:0]    quotient
);
    import srmr_pkg::*;

    logic [STEP_W-1:0]           quo_reg,  quo_next;
    logic                        busy_reg, busy_next;

    logic [RATE_W-1:0]           rate_clamped;
    logic [RATE_W+RECIP_W-1:0]   scaled;

    always_comb begin
        rate_clamped = (rate < MIN_RATE_HZ) ? MIN_RATE_HZ : rate;
        // constant multiply, top bits are the Q16 step
        scaled       = {{RECIP_W{1'b0}}, rate_clamped} * {{RATE_W{1'b0}}, STEP_RECIP};

        quo_next  = quo_reg;
        busy_next = 1'b0;

        if (start) begin
            quo_next  = scaled[RECIP_SHIFT +: STEP_W];
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
